### design/animation_frame_sequencer_unit_macros.svh
// ----------------------------------------------------------------------------
// Animation frame sequencer assertion macros
// Shorthand for clocked implication checks with an active-low reset guard.
// ----------------------------------------------------------------------------
`ifndef ANIMATION_FRAME_SEQUENCER_UNIT_MACROS_SVH
`define ANIMATION_FRAME_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication.
`define AFS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define AFS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/afs_pkg.sv
// ----------------------------------------------------------------------------
// Animation frame sequencer package
// Request/response payloads, request codes and controller/datapath types.
// ----------------------------------------------------------------------------
package afs_pkg;

	localparam int MAX_FRAMES_DEF = 1024;

	localparam int FRAME_W  = 10;             // frame_index / table_index width
	localparam int TICK_W   = 16;             // tick and duration width
	localparam int WORK_W   = TICK_W + 2;     // signed working tick width
	localparam int REQ_W    = 3;
	localparam int CFG_W    = 11;             // widest configuration register
	localparam int CFG_IDX_W = 1;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_ADVANCE = 3'd0;
	localparam logic [REQ_W-1:0] REQ_WRITE   = 3'd1;
	localparam logic [REQ_W-1:0] REQ_RESET   = 3'd2;
	localparam logic [REQ_W-1:0] REQ_PAUSE   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_RESUME  = 3'd4;
	localparam logic [REQ_W-1:0] REQ_STOP    = 3'd5;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_FRAMES = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE  = 1'b1;

	typedef struct packed {
		logic [REQ_W-1:0]          req_type;
		logic signed [TICK_W-1:0]  step_delta;
		logic [FRAME_W-1:0]        table_index;
		logic [TICK_W-1:0]         duration_value;
	} req_t;

	typedef struct packed {
		logic                accepted;
		logic [FRAME_W-1:0]  frame_index;
		logic [TICK_W-1:0]   tick_in_frame;
		logic                at_end;
		logic                at_start;
		logic                is_paused;
		logic                is_stopped;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FWD_RD,
		ST_FWD_EV,
		ST_BWD_CHK,
		ST_BWD_EV,
		ST_LAST_RD,
		ST_LAST_EV,
		ST_FINISH
	} state_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_ACCEPT,
		DP_FWD_STEP,
		DP_FWD_WRAP,
		DP_FWD_CLAMP,
		DP_BWD_STEP,
		DP_BWD_WRAP,
		DP_BWD_CLAMP,
		DP_LAST_TICK,
		DP_PUBLISH
	} dp_op_t;

	typedef enum logic [1:0] {
		RD_CUR,
		RD_PREV,
		RD_LAST
	} rd_sel_t;

	typedef struct packed {
		dp_op_t  op;
		rd_sel_t rd_sel;
	} cmd_t;

	typedef struct packed {
		logic adv_go;        // request is an advance that moves the position
		logic adv_fwd;       // advance delta is positive
		logic loop_en;
		logic out_free;      // response register empty or drained this cycle
		logic tick_ge_dur;   // tick >= duration just read
		logic tick_le_zero;
		logic frame_zero;
		logic frame_at_last; // frame + 1 >= frames in use
	} sts_t;

endpackage

### design/afs_controller.sv
// ----------------------------------------------------------------------------
// Animation frame sequencer controller
// Sequences accept, frame walk, end handling and response publish.
// ----------------------------------------------------------------------------
module afs_controller (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  afs_pkg::sts_t   sts,
	output afs_pkg::cmd_t   cmd
);

	afs_pkg::state_t state_q;
	afs_pkg::state_t state_nxt;
	logic            accept;

	assign req_ready = (state_q == afs_pkg::ST_IDLE) && sts.out_free;
	assign accept    = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= afs_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			afs_pkg::ST_IDLE: begin
				if (accept) begin
					if (sts.adv_go) begin
						state_nxt = sts.adv_fwd ? afs_pkg::ST_FWD_RD : afs_pkg::ST_BWD_CHK;
					end else begin
						state_nxt = afs_pkg::ST_FINISH;
					end
				end
			end
			afs_pkg::ST_FWD_RD: begin
				state_nxt = afs_pkg::ST_FWD_EV;
			end
			afs_pkg::ST_FWD_EV: begin
				if (!sts.tick_ge_dur) begin
					state_nxt = afs_pkg::ST_FINISH;
				end else if (!sts.frame_at_last) begin
					state_nxt = afs_pkg::ST_FWD_RD;
				end else if (sts.loop_en) begin
					state_nxt = afs_pkg::ST_FINISH;
				end else begin
					state_nxt = afs_pkg::ST_LAST_RD;
				end
			end
			afs_pkg::ST_BWD_CHK: begin
				if (!sts.tick_le_zero) begin
					state_nxt = afs_pkg::ST_FINISH;
				end else if (!sts.frame_zero) begin
					state_nxt = afs_pkg::ST_BWD_EV;
				end else if (sts.loop_en) begin
					state_nxt = afs_pkg::ST_LAST_RD;
				end else begin
					state_nxt = afs_pkg::ST_FINISH;
				end
			end
			afs_pkg::ST_BWD_EV: begin
				state_nxt = afs_pkg::ST_BWD_CHK;
			end
			afs_pkg::ST_LAST_RD: begin
				state_nxt = afs_pkg::ST_LAST_EV;
			end
			afs_pkg::ST_LAST_EV: begin
				state_nxt = afs_pkg::ST_FINISH;
			end
			afs_pkg::ST_FINISH: begin
				state_nxt = afs_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = afs_pkg::ST_IDLE;
			end
		endcase
	end

	// Datapath commands
	always_comb begin
		cmd.op     = afs_pkg::DP_NOP;
		cmd.rd_sel = afs_pkg::RD_CUR;
		case (state_q)
			afs_pkg::ST_IDLE: begin
				if (accept) begin
					cmd.op = afs_pkg::DP_ACCEPT;
				end
			end
			afs_pkg::ST_FWD_RD: begin
				cmd.rd_sel = afs_pkg::RD_CUR;
			end
			afs_pkg::ST_FWD_EV: begin
				if (sts.tick_ge_dur) begin
					if (!sts.frame_at_last) begin
						cmd.op = afs_pkg::DP_FWD_STEP;
					end else if (sts.loop_en) begin
						cmd.op = afs_pkg::DP_FWD_WRAP;
					end else begin
						cmd.op = afs_pkg::DP_FWD_CLAMP;
					end
				end
			end
			afs_pkg::ST_BWD_CHK: begin
				if (sts.tick_le_zero) begin
					if (!sts.frame_zero) begin
						cmd.rd_sel = afs_pkg::RD_PREV;
					end else if (sts.loop_en) begin
						cmd.op = afs_pkg::DP_BWD_WRAP;
					end else begin
						cmd.op = afs_pkg::DP_BWD_CLAMP;
					end
				end
			end
			afs_pkg::ST_BWD_EV: begin
				cmd.op = afs_pkg::DP_BWD_STEP;
			end
			afs_pkg::ST_LAST_RD: begin
				cmd.rd_sel = afs_pkg::RD_LAST;
			end
			afs_pkg::ST_LAST_EV: begin
				cmd.op = afs_pkg::DP_LAST_TICK;
			end
			afs_pkg::ST_FINISH: begin
				cmd.op = afs_pkg::DP_PUBLISH;
			end
			default: begin
				cmd.op = afs_pkg::DP_NOP;
			end
		endcase
	end

endmodule

### design/afs_datapath.sv
// ----------------------------------------------------------------------------
// Animation frame sequencer datapath
// Duration table, position and flag registers, config and response register.
// ----------------------------------------------------------------------------
module afs_datapath #(
	parameter int MAX_FRAMES = afs_pkg::MAX_FRAMES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [afs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [afs_pkg::CFG_W-1:0]       cfg_wdata,
	input  afs_pkg::req_t                   req,
	input  logic                            rsp_ready,
	output logic                            rsp_valid,
	output afs_pkg::rsp_t                   rsp,
	input  afs_pkg::cmd_t                   cmd,
	output afs_pkg::sts_t                   sts
);

	localparam int FW  = $clog2(MAX_FRAMES);
	localparam int CW  = $clog2(MAX_FRAMES + 1);
	localparam int TW  = afs_pkg::WORK_W;
	localparam int DW  = afs_pkg::TICK_W;
	localparam int FRW = afs_pkg::FRAME_W;

	logic [DW-1:0]          dur_mem [MAX_FRAMES];
	logic [DW-1:0]          rd_data_q;
	logic [FW-1:0]          rd_addr;
	logic [FW-1:0]          wr_addr;
	logic                   mem_we;

	logic [afs_pkg::CFG_W-1:0] total_frames_q;
	logic                   loop_enable_q;
	logic [CW-1:0]          total_eff;
	logic [FW-1:0]          last_frame;

	logic [FW-1:0]          frame_q;
	logic signed [TW-1:0]   tick_q;
	logic                   end_q;
	logic                   start_q;
	logic                   pause_q;
	logic                   stop_q;
	logic                   acc_q;
	logic                   rsp_valid_q;
	afs_pkg::rsp_t          rsp_q;

	logic signed [TW-1:0]   delta_s;
	logic signed [TW-1:0]   dur_s;
	logic [DW-1:0]          last_tick;

	// Frames in use: zero counts as one, clamp at table depth
	always_comb begin
		if (total_frames_q == '0) begin
			total_eff = CW'(1);
		end else if (32'(total_frames_q) > 32'(MAX_FRAMES)) begin
			total_eff = CW'(MAX_FRAMES);
		end else begin
			total_eff = CW'(total_frames_q);
		end
	end
	assign last_frame = FW'(total_eff - CW'(1));

	assign delta_s   = {{(TW-DW){req.step_delta[DW-1]}}, req.step_delta};
	assign dur_s     = {{(TW-DW){1'b0}}, rd_data_q};
	assign last_tick = (rd_data_q == '0) ? '0 : rd_data_q - DW'(1);

	// Table access
	always_comb begin
		case (cmd.rd_sel)
			afs_pkg::RD_CUR:  rd_addr = frame_q;
			afs_pkg::RD_PREV: rd_addr = frame_q - FW'(1);
			afs_pkg::RD_LAST: rd_addr = last_frame;
			default:          rd_addr = frame_q;
		endcase
	end

	assign wr_addr = FW'(req.table_index);
	assign mem_we  = (cmd.op == afs_pkg::DP_ACCEPT) && (req.req_type == afs_pkg::REQ_WRITE)
		&& (32'(req.table_index) < 32'(MAX_FRAMES));

	always_ff @(posedge clk) begin
		if (mem_we) begin
			dur_mem[wr_addr] <= req.duration_value;
		end
		rd_data_q <= dur_mem[rd_addr];
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_frames_q <= afs_pkg::CFG_W'(1);
			loop_enable_q  <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				afs_pkg::CFG_TOTAL_FRAMES: total_frames_q <= cfg_wdata;
				afs_pkg::CFG_LOOP_ENABLE:  loop_enable_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Position and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
			tick_q  <= '0;
			end_q   <= 1'b0;
			start_q <= 1'b1;
			pause_q <= 1'b0;
			stop_q  <= 1'b0;
			acc_q   <= 1'b1;
		end else begin
			case (cmd.op)
				afs_pkg::DP_ACCEPT: begin
					acc_q <= 1'b1;
					case (req.req_type)
						afs_pkg::REQ_ADVANCE: begin
							if (stop_q) begin
								acc_q <= 1'b0;
							end else if (sts.adv_go) begin
								tick_q  <= tick_q + delta_s;
								end_q   <= 1'b0;
								start_q <= 1'b0;
							end
						end
						afs_pkg::REQ_RESET: begin
							frame_q <= '0;
							tick_q  <= '0;
							end_q   <= 1'b0;
							start_q <= 1'b1;
							pause_q <= 1'b0;
							stop_q  <= 1'b0;
						end
						afs_pkg::REQ_PAUSE: begin
							pause_q <= 1'b1;
						end
						afs_pkg::REQ_RESUME: begin
							pause_q <= 1'b0;
							stop_q  <= 1'b0;
						end
						afs_pkg::REQ_STOP: begin
							stop_q <= 1'b1;
						end
						default: ;
					endcase
				end
				afs_pkg::DP_FWD_STEP: begin
					tick_q  <= tick_q - dur_s;
					frame_q <= frame_q + FW'(1);
				end
				afs_pkg::DP_FWD_WRAP: begin
					end_q   <= 1'b1;
					frame_q <= '0;
					tick_q  <= '0;
				end
				afs_pkg::DP_FWD_CLAMP: begin
					end_q   <= 1'b1;
					pause_q <= 1'b1;
					frame_q <= last_frame;
				end
				afs_pkg::DP_BWD_STEP: begin
					tick_q  <= tick_q + dur_s;
					frame_q <= frame_q - FW'(1);
				end
				afs_pkg::DP_BWD_WRAP: begin
					start_q <= 1'b1;
					frame_q <= last_frame;
				end
				afs_pkg::DP_BWD_CLAMP: begin
					start_q <= 1'b1;
					pause_q <= 1'b1;
					frame_q <= '0;
					tick_q  <= '0;
				end
				afs_pkg::DP_LAST_TICK: begin
					tick_q <= {{(TW-DW){1'b0}}, last_tick};
				end
				default: ;
			endcase
		end
	end

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.op == afs_pkg::DP_PUBLISH) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == afs_pkg::DP_PUBLISH) begin
			rsp_q.accepted      <= acc_q;
			rsp_q.frame_index   <= FRW'(frame_q);
			rsp_q.tick_in_frame <= tick_q[DW-1:0];
			rsp_q.at_end        <= end_q;
			rsp_q.at_start      <= start_q;
			rsp_q.is_paused     <= pause_q;
			rsp_q.is_stopped    <= stop_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Status
	assign sts.adv_go        = (req.req_type == afs_pkg::REQ_ADVANCE) && !stop_q && !pause_q
		&& (req.step_delta != '0);
	assign sts.adv_fwd       = !req.step_delta[DW-1];
	assign sts.loop_en       = loop_enable_q;
	assign sts.out_free      = !rsp_valid_q || rsp_ready;
	assign sts.tick_ge_dur   = (tick_q >= dur_s);
	assign sts.tick_le_zero  = tick_q[TW-1] || (tick_q == '0);
	assign sts.frame_zero    = (frame_q == '0);
	assign sts.frame_at_last = ((CW'(frame_q) + CW'(1)) >= total_eff);

endmodule

### design/animation_frame_sequencer_unit.sv
// Response timing depends on the request: one that does not move the position goes
// straight to publish; an advance walks the table, with a read and evaluate step for
// each frame visited forward, a check and add step for each frame entered backward,
// and a last-entry read and tick load for an end clamp or backward wrap. One request
// is in flight; the next is taken after publish, once the response register is free.
// Reset clears position, flags (start set); config becomes one looping frame; table kept.
// ----------------------------------------------------------------------------
// Animation frame sequencer unit
// Walks a table of per-frame tick durations under advance, write and control
// requests, returning one response per request.
// ----------------------------------------------------------------------------
module animation_frame_sequencer_unit #(
	parameter int MAX_FRAMES = afs_pkg::MAX_FRAMES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write port
	input  logic                            cfg_we,
	input  logic [afs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [afs_pkg::CFG_W-1:0]       cfg_wdata,
	// request channel
	input  logic                            req_valid,
	output logic                            req_ready,
	input  afs_pkg::req_t                   req,
	// response channel
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output afs_pkg::rsp_t                   rsp
);

	// Command and status between the sequencing controller and the datapath.
	// The controller only takes a new request while the response register is
	// empty or draining, so a published response is never overwritten.
	afs_pkg::cmd_t cmd;
	afs_pkg::sts_t sts;

	// Controller: accept, walk frames forward (read, evaluate) or backward
	// (check, read previous, add), then finish end/start handling and publish.
	afs_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: duration table memory with registered read, position and flag
	// registers, configuration registers and the response register.
	afs_datapath #(
		.MAX_FRAMES (MAX_FRAMES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp_ready (rsp_ready),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

### design/afs_checker.sv
// ----------------------------------------------------------------------------
// Animation frame sequencer port checker
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
`include "animation_frame_sequencer_unit_macros.svh"

module afs_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_ready,
	input  logic          rsp_valid,
	input  logic          rsp_ready,
	input  afs_pkg::rsp_t rsp
);

	logic req_fire;
	logic rsp_stall;

	assign req_fire  = req_valid && req_ready;
	assign rsp_stall = rsp_valid && !rsp_ready;

	// Hold a stalled response.
	`AFS_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_stall, rsp_valid && $stable(rsp), "response dropped or changed while stalled")

	// Take no request while an undelivered response would block its result.
	`AFS_ASSERT_IMP(a_no_overrun, clk, arst_n, req_fire, !rsp_stall, "request taken while response stalled")

	// Refuse only when stopped.
	`AFS_ASSERT_IMP(a_refuse_stopped, clk, arst_n, rsp_valid && !rsp.accepted, rsp.is_stopped, "refusal without stop")

	// End and start never both raised.
	`AFS_ASSERT_IMP(a_end_start, clk, arst_n, rsp_valid, !(rsp.at_end && rsp.at_start), "end and start flags both set")

endmodule

bind animation_frame_sequencer_unit afs_checker u_afs_checker (.*);

### tb/animation_frame_sequencer_unit_tb.sv
// ----------------------------------------------------------------------------
// Animation frame sequencer unit testbench
// Drives duration writes, advances and control requests through the request
// channel, tracks frame, tick and flags alongside the unit and compares every
// response field against that tracked state, with random stalls on both sides.
// ----------------------------------------------------------------------------
module animation_frame_sequencer_unit_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_FR = afs_pkg::MAX_FRAMES_DEF;

	// Request codes the unit must ignore.
	localparam logic [afs_pkg::REQ_W-1:0] REQ_SPARE_A = 3'd6;
	localparam logic [afs_pkg::REQ_W-1:0] REQ_SPARE_B = 3'd7;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_we;
	logic [afs_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [afs_pkg::CFG_W-1:0]     cfg_wdata;
	logic                          req_valid;
	logic                          req_ready;
	afs_pkg::req_t                 req;
	logic                          rsp_valid;
	logic                          rsp_ready;
	afs_pkg::rsp_t                 rsp;

	// Tracked animation state, updated as each request is issued.
	logic [afs_pkg::TICK_W-1:0] dur_tbl [MAX_FR];
	bit                written [MAX_FR];
	int                frame_pos = 0;
	int                tick_pos  = 0;
	bit                end_on    = 1'b0;
	bit                start_on  = 1'b1;
	bit                pause_on  = 1'b0;
	bit                stop_on   = 1'b0;
	int                cfg_total = 1;
	bit                cfg_loop  = 1'b1;

	afs_pkg::rsp_t     awaited_status [$];
	int                mismatch_count = 0;
	bit                idling = 1'b1;

	animation_frame_sequencer_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------
	// Animation state tracking
	// ------------------------------------------------------------------

	function automatic int frames_used();
		if (cfg_total == 0) return 1;
		if (cfg_total > MAX_FR) return MAX_FR;
		return cfg_total;
	endfunction

	// Remember the first table entry read that was never written.
	function automatic int note_read(int miss, int f);
		return (miss < 0 && !written[f]) ? f : miss;
	endfunction

	// Clamp or wrap target tick: last tick of the frame, zero for an empty frame.
	function automatic int last_tick(int f);
		return (dur_tbl[f] > 0) ? int'(dur_tbl[f]) - 1 : 0;
	endfunction

	// Walk the position by delta ticks. Returns the first unwritten entry the
	// walk would read, or -1; commit the new position and flags when asked.
	function automatic int walk_frames(int delta, bit commit);
		int total;
		int f;
		int t;
		int miss;
		bit e;
		bit s;
		bit p;
		total = frames_used();
		f     = frame_pos;
		t     = tick_pos + delta;
		miss  = -1;
		e     = 1'b0;
		s     = 1'b0;
		p     = pause_on;
		if (delta > 0) begin
			// Forward: consume whole frames; a frame beyond the count exits at once.
			while (1'b1) begin
				miss = note_read(miss, f);
				if (t < int'(dur_tbl[f])) break;
				t -= int'(dur_tbl[f]);
				f++;
				if (f >= total) begin
					e = 1'b1;
					if (!cfg_loop) begin
						p    = 1'b1;
						f    = total - 1;
						miss = note_read(miss, f);
						t    = last_tick(f);
					end else begin
						f = 0;
						t = 0;
					end
					break;
				end
			end
		end else begin
			// Backward: borrow from earlier frames; frame -1 is never read.
			while (t <= 0) begin
				f--;
				if (f < 0) begin
					s = 1'b1;
					if (!cfg_loop) begin
						p = 1'b1;
						f = 0;
						t = 0;
					end else begin
						f    = total - 1;
						miss = note_read(miss, f);
						t    = last_tick(f);
					end
					break;
				end
				miss = note_read(miss, f);
				t += int'(dur_tbl[f]);
			end
		end
		if (commit) begin
			frame_pos = f;
			tick_pos  = t;
			end_on    = e;
			start_on  = s;
			pause_on  = p;
		end
		return miss;
	endfunction

	// Apply one request to the tracked state and return the status it yields.
	function automatic afs_pkg::rsp_t apply_to_animation(afs_pkg::req_t r);
		afs_pkg::rsp_t o;
		o.accepted = 1'b1;
		case (r.req_type)
			afs_pkg::REQ_ADVANCE: begin
				if (stop_on) o.accepted = 1'b0;
				else if (!pause_on && r.step_delta != 0)
					void'(walk_frames(int'(r.step_delta), 1'b1));
			end
			afs_pkg::REQ_WRITE: begin
				dur_tbl[r.table_index] = r.duration_value;
				written[r.table_index] = 1'b1;
			end
			afs_pkg::REQ_RESET: begin
				frame_pos = 0;
				tick_pos  = 0;
				end_on    = 1'b0;
				start_on  = 1'b1;
				pause_on  = 1'b0;
				stop_on   = 1'b0;
			end
			afs_pkg::REQ_PAUSE:  pause_on = 1'b1;
			afs_pkg::REQ_RESUME: begin
				pause_on = 1'b0;
				stop_on  = 1'b0;
			end
			afs_pkg::REQ_STOP:   stop_on = 1'b1;
			default: ;
		endcase
		o.frame_index   = afs_pkg::FRAME_W'(frame_pos);
		o.tick_in_frame = afs_pkg::TICK_W'(tick_pos);
		o.at_end        = end_on;
		o.at_start      = start_on;
		o.is_paused     = pause_on;
		o.is_stopped    = stop_on;
		return o;
	endfunction

	// ------------------------------------------------------------------
	// Request building
	// ------------------------------------------------------------------

	function automatic afs_pkg::req_t make_req(logic [afs_pkg::REQ_W-1:0] code, int delta,
		int idx, int dur);
		afs_pkg::req_t r;
		r.req_type       = code;
		r.step_delta     = afs_pkg::TICK_W'(delta);
		r.table_index    = afs_pkg::FRAME_W'(idx);
		r.duration_value = afs_pkg::TICK_W'(dur);
		return r;
	endfunction

	// Mostly short frames so walks cross several of them; empty and huge ones too.
	function automatic logic [afs_pkg::TICK_W-1:0] pick_duration();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 6) return afs_pkg::TICK_W'($urandom_range(1, 8));
		if (sel == 6) return '0;
		if (sel == 7) return '1;
		return afs_pkg::TICK_W'($urandom);
	endfunction

	function automatic afs_pkg::req_t random_request();
		afs_pkg::req_t r;
		int   pick;
		int   sel;
		int   mag;
		int   top;
		// Unused fields carry noise.
		r.step_delta     = afs_pkg::TICK_W'($urandom);
		r.table_index    = afs_pkg::FRAME_W'($urandom);
		r.duration_value = afs_pkg::TICK_W'($urandom);
		pick = $urandom_range(0, 99);
		if ((pause_on || stop_on) && pick < 50) begin
			// Get moving again most of the time, or nothing deep is reached.
			r.req_type = afs_pkg::REQ_RESUME;
		end else if (pick < 60) begin
			r.req_type = afs_pkg::REQ_ADVANCE;
			sel = $urandom_range(0, 9);
			mag = (sel < 6) ? $urandom_range(1, 12) : $urandom_range(13, 400);
			if (sel < 8) begin
				r.step_delta = afs_pkg::TICK_W'($urandom_range(0, 1) ? mag : -mag);
			end else if (sel == 9) begin
				case ($urandom_range(0, 2))
					0: r.step_delta = 16'sh7FFF;
					1: r.step_delta = 16'sh8000;
					default: r.step_delta = '0;
				endcase
			end
		end else if (pick < 80) begin
			r.req_type = afs_pkg::REQ_WRITE;
			top = (frames_used() > MAX_FR - 1) ? MAX_FR - 1 : frames_used();
			if ($urandom_range(0, 9) != 0) begin
				r.table_index = afs_pkg::FRAME_W'($urandom_range(0, top));
			end
			r.duration_value = pick_duration();
		end else if (pick < 85) begin
			r.req_type = afs_pkg::REQ_RESET;
		end else if (pick < 90) begin
			r.req_type = afs_pkg::REQ_PAUSE;
		end else if (pick < 96) begin
			r.req_type = afs_pkg::REQ_RESUME;
		end else if (pick < 99) begin
			r.req_type = afs_pkg::REQ_STOP;
		end else begin
			r.req_type = $urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B;
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Channel drivers
	// ------------------------------------------------------------------

	// Present one request at the falling edge, hold it until taken, then
	// queue the status it must produce. Valid stays up between back-to-back
	// requests unless a gap is drawn.
	task automatic send_request(afs_pkg::req_t r);
		afs_pkg::rsp_t want;
		int   gap;
		gap = (idling && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		want = apply_to_animation(r);
		do @(posedge clk); while (!req_ready);
		awaited_status.push_back(want);
	endtask

	// Drop valid and hold off until every awaited response is in.
	task automatic drain_responses();
		@(negedge clk);
		req_valid <= 1'b0;
		while (awaited_status.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// Write one register; only called with the unit idle.
	task automatic write_register(logic [afs_pkg::CFG_IDX_W-1:0] idx,
		logic [afs_pkg::CFG_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		if (idx == afs_pkg::CFG_TOTAL_FRAMES) cfg_total = int'(value);
		else cfg_loop = value[0];
	endtask

	// Send random requests; an advance that would read a never-written entry
	// becomes a write of that entry instead.
	task automatic issue_random(int count);
		afs_pkg::req_t r;
		int   miss;
		repeat (count) begin
			r = random_request();
			if (r.req_type == afs_pkg::REQ_ADVANCE && !stop_on && !pause_on
				&& r.step_delta != 0) begin
				miss = walk_frames(int'(r.step_delta), 1'b0);
				if (miss >= 0) begin
					r = make_req(afs_pkg::REQ_WRITE, $urandom, miss, pick_duration());
				end
			end
			send_request(r);
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Looping walks: largest deltas, empty frame, wraps both ways, zero delta,
	// pause, stop, writes while stopped, spare codes and reset.
	task automatic test_wrap_and_special_cases();
		write_register(afs_pkg::CFG_TOTAL_FRAMES, 11'd4);
		write_register(afs_pkg::CFG_LOOP_ENABLE, 11'h7FF);
		send_request(make_req(afs_pkg::REQ_RESUME, 0, 0, 0));
		send_request(make_req(afs_pkg::REQ_WRITE, 0, 0, 65535));
		send_request(make_req(afs_pkg::REQ_WRITE, 0, 1, 1));
		send_request(make_req(afs_pkg::REQ_WRITE, 0, 2, 0));
		send_request(make_req(afs_pkg::REQ_WRITE, 0, 3, 3));
		send_request(make_req(afs_pkg::REQ_WRITE, -1, 1023, 1));
		send_request(make_req(afs_pkg::REQ_ADVANCE, 32767, 0, 0));
		send_request(make_req(afs_pkg::REQ_ADVANCE, 32767, 0, 0));
		send_request(make_req(afs_pkg::REQ_ADVANCE, 1, 0, 0));
		send_request(make_req(afs_pkg::REQ_ADVANCE, 0, 1023, 65535));
		// walk through the empty frame into the next one
		send_request(make_req(afs_pkg::REQ_ADVANCE, 1, 0, 0));
		send_request(make_req(afs_pkg::REQ_ADVANCE, 5, 0, 0));
		send_request(make_req(afs_pkg::REQ_ADVANCE, -32768, 0, 0));
		send_request(make_req(afs_pkg::REQ_PAUSE, 0, 0, 0));
		send_request(make_req(afs_pkg::REQ_ADVANCE, 1, 0, 0));
		send_request(make_req(afs_pkg::REQ_STOP, 0, 0, 0));
		send_request(make_req(afs_pkg::REQ_ADVANCE, -1, 0, 0));
		send_request(make_req(afs_pkg::REQ_WRITE, 0, 2, 2));
		send_request(make_req(afs_pkg::REQ_RESUME, 0, 0, 0));
		send_request(make_req(REQ_SPARE_A, 0, 0, 0));
		send_request(make_req(REQ_SPARE_B, 0, 0, 0));
		send_request(make_req(afs_pkg::REQ_RESET, 0, 0, 0));
	endtask

	// Clamping at both ends, a frame left beyond a lowered count, and frame
	// counts of zero and above the table size.
	task automatic test_clamp_and_register_limits();
		drain_responses();
		write_register(afs_pkg::CFG_LOOP_ENABLE, 11'h7FE);
		send_request(make_req(afs_pkg::REQ_ADVANCE, -1, 0, 0));
		send_request(make_req(afs_pkg::REQ_RESUME, 0, 0, 0));
		send_request(make_req(afs_pkg::REQ_WRITE, 0, 0, 2));
		send_request(make_req(afs_pkg::REQ_ADVANCE, 32767, 0, 0));
		send_request(make_req(afs_pkg::REQ_RESUME, 0, 0, 0));
		drain_responses();
		write_register(afs_pkg::CFG_TOTAL_FRAMES, 11'd2);
		send_request(make_req(afs_pkg::REQ_ADVANCE, 1, 0, 0));
		drain_responses();
		write_register(afs_pkg::CFG_TOTAL_FRAMES, 11'd0);
		write_register(afs_pkg::CFG_LOOP_ENABLE, 11'd1);
		send_request(make_req(afs_pkg::REQ_RESUME, 0, 0, 0));
		send_request(make_req(afs_pkg::REQ_ADVANCE, -1, 0, 0));
		send_request(make_req(afs_pkg::REQ_ADVANCE, 1, 0, 0));
		drain_responses();
		write_register(afs_pkg::CFG_TOTAL_FRAMES, 11'h7FF);
		send_request(make_req(afs_pkg::REQ_ADVANCE, -1, 0, 0));
		send_request(make_req(afs_pkg::REQ_ADVANCE, 1, 0, 0));
		send_request(make_req(afs_pkg::REQ_RESET, 0, 0, 0));
	endtask

	// Random phases, each under fresh register settings, mostly short animations.
	task automatic test_random_phases(int phases);
		logic [afs_pkg::CFG_W-1:0] count;
		int               sel;
		for (int ph = 0; ph < phases; ph++) begin
			drain_responses();
			sel = $urandom_range(0, 9);
			if (sel == 0) count = '0;
			else if (sel < 3) count = afs_pkg::CFG_W'(sel);
			else if (sel < 8) count = afs_pkg::CFG_W'($urandom_range(3, 16));
			else if (sel == 8) count = afs_pkg::CFG_W'(MAX_FR);
			else count = afs_pkg::CFG_W'($urandom_range(MAX_FR + 1, 2047));
			write_register(afs_pkg::CFG_TOTAL_FRAMES, count);
			write_register(afs_pkg::CFG_LOOP_ENABLE, afs_pkg::CFG_W'($urandom));
			idling = ($urandom_range(0, 3) != 0);
			issue_random(60);
		end
	endtask

	// Full-size animation; the table fills in as walks reach new frames.
	task automatic test_full_table();
		drain_responses();
		write_register(afs_pkg::CFG_TOTAL_FRAMES, afs_pkg::CFG_W'(MAX_FR));
		write_register(afs_pkg::CFG_LOOP_ENABLE, afs_pkg::CFG_W'($urandom));
		idling = 1'b1;
		issue_random(80);
	endtask

	// Back-to-back requests with the response side always ready.
	task automatic test_steady_stream();
		idling = 1'b0;
		issue_random(60);
	endtask

	// ------------------------------------------------------------------
	// Response side
	// ------------------------------------------------------------------

	// Stall the response channel at random while idling.
	initial begin : rsp_throttle
		rsp_ready = 1'b1;
		forever begin
			@(negedge clk);
			if (idling && $urandom_range(0, 3) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(0, 8)) @(negedge clk);
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Compare each response taken against the oldest awaited status.
	always @(posedge clk) begin : check_status
		afs_pkg::rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (awaited_status.size() == 0) begin
				$display("%0t: response with none awaited, expected none, actual %p",
					$time, rsp);
				mismatch_count++;
			end else begin
				want = awaited_status.pop_front();
				check_field("accepted", want.accepted, rsp.accepted);
				check_field("frame_index", want.frame_index, rsp.frame_index);
				check_field("tick_in_frame", want.tick_in_frame, rsp.tick_in_frame);
				check_field("at_end", want.at_end, rsp.at_end);
				check_field("at_start", want.at_start, rsp.at_start);
				check_field("is_paused", want.is_paused, rsp.is_paused);
				check_field("is_stopped", want.is_stopped, rsp.is_stopped);
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		req_valid = 1'b0;
		req       = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_wrap_and_special_cases();
		test_clamp_and_register_limits();
		test_random_phases(10);
		test_full_table();
		test_steady_stream();

		// Let the last responses land, then give the unit time to misbehave.
		drain_responses();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// Hang guard: far beyond the slowest legal run, even with every request
	// walking the whole table under the longest stalls.
	initial begin
		#200_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
